### sv/qte_pkg.sv
// Shared types, constants and the arctangent table for the quaternion to Euler core.
// No dependencies; the cells and the core import this package.
package qte_pkg;

  localparam int VecW      = 45;  // CORDIC vector component width
  localparam int AngW      = 29;  // Q.24 angle accumulator width
  localparam int MagW      = 42;  // magnitude used by normalization
  localparam int SqVW      = 57;  // radicand width (Q.56 of 1 - s^2)
  localparam int SqRW      = 58;  // root / partial root width
  localparam int SqrtCells = 29;  // one root bit per cell
  localparam int NormCells = 6;   // shift steps 32, 16, 8, 4, 2, 1
  localparam int AtanLen   = 24;
  localparam int NormTop   = 41;  // normalized magnitude lies below 2^41

  localparam logic signed [AngW-1:0] AngPi     = 29'sd52707179;
  localparam logic signed [15:0]     OutPi     = 16'sd25736;
  localparam logic signed [15:0]     OutHalfPi = 16'sd12868;

  typedef struct packed {
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
    logic [MagW-1:0]        mx;
    logic signed [AngW-1:0] ang;
    logic                   zero;
    logic                   tag;
  } vec_t;

  typedef struct packed {
    logic [SqVW-1:0] v;
    logic [SqRW-1:0] res;
  } sqrt_t;

  typedef struct packed {
    logic signed [33:0] roll_n;
    logic signed [33:0] roll_d;
    logic signed [33:0] yaw_n;
    logic signed [33:0] yaw_d;
    logic signed [29:0] s;
    logic               clamped;
  } side_t;

  // atan(2^-i) in radians, Q.24
  function automatic logic signed [AngW-1:0] atan_q24(input int idx);
    logic signed [AngW-1:0] r;
    case (idx)
      0:  r = 29'sd13176795;
      1:  r = 29'sd7778716;
      2:  r = 29'sd4110060;
      3:  r = 29'sd2086331;
      4:  r = 29'sd1047214;
      5:  r = 29'sd524117;
      6:  r = 29'sd262123;
      7:  r = 29'sd131069;
      8:  r = 29'sd65536;
      9:  r = 29'sd32768;
      10: r = 29'sd16384;
      11: r = 29'sd8192;
      12: r = 29'sd4096;
      13: r = 29'sd2048;
      14: r = 29'sd1024;
      15: r = 29'sd512;
      16: r = 29'sd256;
      17: r = 29'sd128;
      18: r = 29'sd64;
      19: r = 29'sd32;
      20: r = 29'sd16;
      21: r = 29'sd8;
      22: r = 29'sd4;
      23: r = 29'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### sv/qte_quat_if.sv
// Valid/ready channel carrying one quaternion item (four signed Q2.14 components).
// No dependencies.
interface qte_quat_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;

  modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

### sv/qte_euler_if.sv
// Valid/ready channel carrying one Euler angle item (Q3.13 roll and yaw, Q2.13 pitch, and clamp flag).
// No dependencies.
interface qte_euler_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_angle;
  logic signed [14:0] pitch_angle;
  logic signed [15:0] yaw_angle;
  logic               pitch_clamped;

  modport source (output valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                  input ready);
  modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                  output ready);
endinterface

### sv/qte_sqrt_cell.sv
// One cell of the restoring square root chain: settles one root bit per cycle while en_i is high.
// Depends on qte_pkg.
module qte_sqrt_cell import qte_pkg::*; #(
  parameter int SHIFT = 56
) (
  input  logic  clk_i,
  input  logic  en_i,
  input  sqrt_t in_i,
  output sqrt_t out_o
);

  localparam logic [SqRW-1:0] Bit = SqRW'(1) << SHIFT;

  sqrt_t           cell_d, cell_q;
  logic [SqRW-1:0] trial;

  always_comb begin
    trial  = in_i.res + Bit;
    cell_d = in_i;
    if (SqRW'(in_i.v) >= trial) begin
      cell_d.v   = in_i.v - SqVW'(trial);
      cell_d.res = (in_i.res >> 1) + Bit;
    end else begin
      cell_d.res = in_i.res >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign out_o = cell_q;

endmodule

### sv/qte_norm_cell.sv
// One step of the normalizing shifter: shift the vector left by K when it stays in range.
// Depends on qte_pkg.
module qte_norm_cell import qte_pkg::*; #(
  parameter int K = 32
) (
  input  logic clk_i,
  input  logic en_i,
  input  vec_t in_i,
  output vec_t out_o
);

  localparam logic [MagW-1:0] Limit = MagW'(1) << (NormTop - K);

  vec_t cell_d, cell_q;

  always_comb begin
    cell_d = in_i;
    if (in_i.mx < Limit) begin
      cell_d.x  = in_i.x <<< K;
      cell_d.y  = in_i.y <<< K;
      cell_d.mx = in_i.mx << K;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign out_o = cell_q;

endmodule

### sv/qte_cordic_cell.sv
// One vectoring micro-rotation of the CORDIC chain, index I.
// Depends on qte_pkg.
module qte_cordic_cell import qte_pkg::*; #(
  parameter int I = 0
) (
  input  logic clk_i,
  input  logic en_i,
  input  vec_t in_i,
  output vec_t out_o
);

  localparam logic signed [AngW-1:0] Step = atan_q24(I);

  vec_t                 cell_d, cell_q;
  logic signed [VecW-1:0] dx, dy;

  always_comb begin
    dx     = in_i.y >>> I;
    dy     = in_i.x >>> I;
    cell_d = in_i;
    if (in_i.y > 0) begin
      cell_d.x   = in_i.x + dx;
      cell_d.y   = in_i.y - dy;
      cell_d.ang = in_i.ang + Step;
    end else begin
      cell_d.x   = in_i.x - dx;
      cell_d.y   = in_i.y + dy;
      cell_d.ang = in_i.ang - Step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign out_o = cell_q;

endmodule

### sv/quaternion_to_euler_angles_core.sv
// Top level of the quaternion to roll/pitch/yaw converter.
// Depends on qte_pkg, qte_quat_if, qte_euler_if and the sqrt, norm and CORDIC cells.
//
// Converts one quaternion (signed Q2.14, need not be unit length) into roll,
// pitch and yaw in radians, signed Q3.13 (pitch Q2.13). The block is one
// stall-able pipeline: it accepts one item every cycle while the output is not
// stalled. Each item passes the product, sum and square registers, the 29-cell
// square root chain for the pitch cosine term, the setup registers, six
// normalizing shift cells, one CORDIC cell per micro-rotation (CORDIC_STAGES
// capped at 24) and the output registers. When the result is not taken the
// whole pipeline holds, so input ready follows output ready while a result is
// waiting. pitch_clamped flags items whose asin argument exceeded one.
module quaternion_to_euler_angles_core import qte_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  qte_quat_if.sink    quat_i,
  qte_euler_if.source euler_o
);

  localparam int NStg  = (CORDIC_STAGES > AtanLen) ? AtanLen : CORDIC_STAGES;
  localparam int Depth = 3 + SqrtCells + 1 + NormCells + NStg + 1;

  localparam logic signed [33:0] OneQ28 = 34'sd268435456;
  localparam logic [SqVW-1:0]    OneSq  = SqVW'(1) << 56;

  // global advance: hold every stage while the output waits
  logic             en;
  logic [Depth-1:0] vld_q;

  assign en           = !vld_q[Depth-1] || euler_o.ready;
  assign quat_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], quat_i.valid};
    end
  end

  // stage 1: all ten products
  logic signed [31:0] xx_q, yy_q, zz_q, ww_q, yz_q, wx_q, xy_q, wz_q, wy_q, xz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      xx_q <= quat_i.quat_x * quat_i.quat_x;
      yy_q <= quat_i.quat_y * quat_i.quat_y;
      zz_q <= quat_i.quat_z * quat_i.quat_z;
      ww_q <= quat_i.quat_w * quat_i.quat_w;
      yz_q <= quat_i.quat_y * quat_i.quat_z;
      wx_q <= quat_i.quat_w * quat_i.quat_x;
      xy_q <= quat_i.quat_x * quat_i.quat_y;
      wz_q <= quat_i.quat_w * quat_i.quat_z;
      wy_q <= quat_i.quat_w * quat_i.quat_y;
      xz_q <= quat_i.quat_x * quat_i.quat_z;
    end
  end

  // stage 2: numerators, denominators and the clamped asin argument
  side_t              side_d;
  side_t              side_q [SqrtCells+2];
  logic signed [33:0] s_raw;

  always_comb begin
    side_d.roll_n = (34'(yz_q) + 34'(wx_q)) <<< 1;
    side_d.roll_d = 34'(ww_q) - 34'(xx_q) - 34'(yy_q) + 34'(zz_q);
    side_d.yaw_n  = (34'(xy_q) + 34'(wz_q)) <<< 1;
    side_d.yaw_d  = 34'(ww_q) + 34'(xx_q) - 34'(yy_q) - 34'(zz_q);
    s_raw         = (34'(wy_q) - 34'(xz_q)) <<< 1;
    side_d.clamped = 1'b0;
    side_d.s       = 30'(s_raw);
    if (s_raw > OneQ28) begin
      side_d.s       = 30'(OneQ28);
      side_d.clamped = 1'b1;
    end else if (s_raw < -OneQ28) begin
      side_d.s       = 30'(-OneQ28);
      side_d.clamped = 1'b1;
    end
  end

  // stage 3 onward: carry the side data alongside the root chain
  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_d;
      for (int k = 1; k < SqrtCells + 2; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // stage 3: s squared
  logic signed [59:0] s_sq;
  logic [SqVW-1:0]    ssq_q;

  assign s_sq = side_q[0].s * side_q[0].s;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ssq_q <= SqVW'(s_sq);
    end
  end

  // root chain: cos term = floor(sqrt(2^56 - s^2))
  sqrt_t sqrt_s [SqrtCells+1];

  assign sqrt_s[0].v   = OneSq - ssq_q;
  assign sqrt_s[0].res = '0;

  for (genvar k = 0; k < SqrtCells; k++) begin : g_sqrt
    qte_sqrt_cell #(.SHIFT(56 - 2*k)) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .in_i  (sqrt_s[k]),
      .out_o (sqrt_s[k+1])
    );
  end

  // setup: fold the left half plane, flag the zero vector, take the magnitude
  function automatic vec_t setup_vec(input logic signed [VecW-1:0] y_in,
                                     input logic signed [VecW-1:0] x_in,
                                     input logic tag_in);
    vec_t                   r;
    logic signed [VecW-1:0] ay;
    r.x    = x_in;
    r.y    = y_in;
    r.ang  = '0;
    r.tag  = tag_in;
    r.zero = (x_in == '0) && (y_in == '0);
    if (x_in < 0) begin
      r.ang = (y_in >= 0) ? AngPi : -AngPi;
      r.x   = -x_in;
      r.y   = -y_in;
    end
    ay   = (r.y < 0) ? -r.y : r.y;
    r.mx = (r.x > ay) ? MagW'(r.x) : MagW'(ay);
    return r;
  endfunction

  side_t sd;
  vec_t  pre_q [3];

  assign sd = side_q[SqrtCells+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      pre_q[0] <= setup_vec(VecW'(sd.roll_n), VecW'(sd.roll_d), 1'b0);
      pre_q[1] <= setup_vec(VecW'(sd.s), VecW'(sqrt_s[SqrtCells].res), sd.clamped);
      pre_q[2] <= setup_vec(VecW'(sd.yaw_n), VecW'(sd.yaw_d), 1'b0);
    end
  end

  // per angle: normalizing shifter then CORDIC chain
  vec_t nrm_s [3][NormCells+1];
  vec_t cor_s [3][NStg+1];

  for (genvar p = 0; p < 3; p++) begin : g_path
    assign nrm_s[p][0] = pre_q[p];
    for (genvar j = 0; j < NormCells; j++) begin : g_norm
      qte_norm_cell #(.K(32 >> j)) u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .in_i  (nrm_s[p][j]),
        .out_o (nrm_s[p][j+1])
      );
    end
    assign cor_s[p][0] = nrm_s[p][NormCells];
    for (genvar i = 0; i < NStg; i++) begin : g_cordic
      qte_cordic_cell #(.I(i)) u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .in_i  (cor_s[p][i]),
        .out_o (cor_s[p][i+1])
      );
    end
  end

  // round half up to Q3.13 and saturate
  function automatic logic signed [15:0] to_q13(input vec_t v,
                                                input logic signed [15:0] lim);
    logic signed [29:0] t;
    logic signed [18:0] r;
    t = v.zero ? 30'sd1024 : (30'(v.ang) + 30'sd1024);
    r = 19'(t >>> 11);
    if (r > 19'(lim)) begin
      r = 19'(lim);
    end else if (r < -19'(lim)) begin
      r = -19'(lim);
    end
    return 16'(r);
  endfunction

  logic signed [15:0] roll_q, yaw_q;
  logic signed [14:0] pitch_q;
  logic               clamp_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_q  <= to_q13(cor_s[0][NStg], OutPi);
      pitch_q <= 15'(to_q13(cor_s[1][NStg], OutHalfPi));
      yaw_q   <= to_q13(cor_s[2][NStg], OutPi);
      clamp_q <= cor_s[1][NStg].tag;
    end
  end

  assign euler_o.valid         = vld_q[Depth-1];
  assign euler_o.roll_angle    = roll_q;
  assign euler_o.pitch_angle   = pitch_q;
  assign euler_o.yaw_angle     = yaw_q;
  assign euler_o.pitch_clamped = clamp_q;

endmodule

### sv/qte_checker.sv
// Port-level checks for the quaternion to Euler core, attached by bind.
// Depends on quaternion_to_euler_angles_core.
module qte_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic signed [15:0] roll_i,
  input logic signed [14:0] pitch_i,
  input logic               clamp_i
);

  // an empty output never blocks the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i) else $error("input stalled with empty output");

  // a waiting result is held
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(roll_i))
    else $error("waiting result dropped or changed");

  // a clamped argument pins pitch at plus or minus half pi
  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && clamp_i |-> (pitch_i == 15'sd12868) || (pitch_i == -15'sd12868))
    else $error("clamped pitch not at half pi");

  // roll stays within plus or minus pi
  a_roll_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (roll_i <= 16'sd25736) && (roll_i >= -16'sd25736))
    else $error("roll out of range");

endmodule

bind quaternion_to_euler_angles_core qte_checker u_qte_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (quat_i.ready),
  .out_valid_i (euler_o.valid),
  .out_ready_i (euler_o.ready),
  .roll_i      (euler_o.roll_angle),
  .pitch_i     (euler_o.pitch_angle),
  .clamp_i     (euler_o.pitch_clamped)
);
